// ===== hw/rtl/prsd_pkg.sv =====
package prsd_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int SUM_BITS  = 52;
  localparam int ACC_BITS  = SUM_BITS + 2;
  localparam int CNT_BITS  = 17;
  localparam int RMSD_BITS = 17;

  // Magnitudes are viewed at a fixed width; one square is exact below 2^HALF_BITS.
  localparam int MAG_BITS  = 34;
  localparam int HALF_BITS = SUM_BITS / 2;

  localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};
  localparam logic [RMSD_BITS-1:0] RMSD_MAX = {RMSD_BITS{1'b1}};

  localparam int MAX_POINTS    = 65536;
  localparam int CNT_FIELD_MAX = (1 << CNT_BITS) - 1;
  localparam int COUNT_CAP     = (MAX_POINTS < CNT_FIELD_MAX) ? MAX_POINTS : CNT_FIELD_MAX;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = 2;
  localparam int QCNT_BITS  = QPTR_BITS + 1;

  localparam int DIV_STEPS  = SUM_BITS;
  localparam int SQRT_STEPS = SUM_BITS / 2;
  localparam int STEP_BITS  = 6;

  // One finished set, handed from the accumulator to the back end.
  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0] count;
    logic                sat;
  } set_t;

endpackage

// ===== hw/rtl/prsd_front.sv =====
module prsd_front #(
  parameter int COORD_BITS = prsd_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by_coord,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic                         last_pair,
  output logic                         set_valid,
  output prsd_pkg::set_t               set_data,
  output logic [1:0]                   lasts_in_flight
);
  import prsd_pkg::*;

  localparam int MW = COORD_BITS + 1;

  logic signed [MW-1:0] diff [3];
  logic [MW-1:0]        mag_in [3];

  logic                 v1, l1;
  logic [MW-1:0]        mag1 [3];

  logic [MAG_BITS-1:0]  mag_w [3];
  logic [HALF_BITS-1:0] mag_lo [3];
  logic [SUM_BITS-1:0]  prod [3];
  logic [2:0]           big_w;

  logic                 v2, l2, big2;
  logic [SUM_BITS-1:0]  sq2 [3];

  logic                 v3, l3, big3;
  logic [ACC_BITS-1:0]  sum3;

  logic [SUM_BITS-1:0]  running_sum;
  logic [CNT_BITS-1:0]  pairs_seen;
  logic                 saturated;

  logic [ACC_BITS-1:0]  total;
  logic                 drop, over;
  logic [SUM_BITS-1:0]  running_sum_next;
  logic [CNT_BITS-1:0]  pairs_seen_next;
  logic                 saturated_next;

  always_comb begin
    diff[0] = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    diff[1] = {ay[COORD_BITS-1], ay} - {by_coord[COORD_BITS-1], by_coord};
    diff[2] = {az[COORD_BITS-1], az} - {bz[COORD_BITS-1], bz};
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = diff[i][MW-1] ? MW'(-diff[i]) : MW'(diff[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i]  = MAG_BITS'(mag1[i]);
      mag_lo[i] = mag_w[i][HALF_BITS-1:0];
      big_w[i]  = |mag_w[i][MAG_BITS-1:HALF_BITS];
      prod[i]   = {{HALF_BITS{1'b0}}, mag_lo[i]} * {{HALF_BITS{1'b0}}, mag_lo[i]};
    end
  end

  // Saturating adds of non-negative terms: clamping once at the end is the same
  // as clamping after each add.
  always_comb begin
    total = ACC_BITS'(running_sum) + sum3;
    drop  = pairs_seen >= CNT_BITS'(COUNT_CAP);
    over  = big3 || (total > ACC_BITS'(SUM_MAX));
    if (drop) begin
      running_sum_next = running_sum;
      pairs_seen_next  = pairs_seen;
      saturated_next   = 1'b1;
    end else begin
      running_sum_next = over ? SUM_MAX : total[SUM_BITS-1:0];
      pairs_seen_next  = pairs_seen + 1'b1;
      saturated_next   = saturated | over;
    end
  end

  assign set_valid       = v3 && l3;
  assign set_data.sum    = running_sum_next;
  assign set_data.count  = pairs_seen_next;
  assign set_data.sat    = saturated_next;
  assign lasts_in_flight = {1'b0, v1 && l1} + {1'b0, v2 && l2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      running_sum <= '0;
      pairs_seen  <= '0;
      saturated   <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      if (v3) begin
        if (l3) begin
          running_sum <= '0;
          pairs_seen  <= '0;
          saturated   <= 1'b0;
        end else begin
          running_sum <= running_sum_next;
          pairs_seen  <= pairs_seen_next;
          saturated   <= saturated_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    l1 <= last_pair;
    for (int i = 0; i < 3; i++) begin
      mag1[i] <= mag_in[i];
      sq2[i]  <= prod[i];
    end
    l2   <= l1;
    big2 <= |big_w;
    l3   <= l2;
    big3 <= big2;
    sum3 <= ACC_BITS'(sq2[0]) + ACC_BITS'(sq2[1]) + ACC_BITS'(sq2[2]);
  end

endmodule

// ===== hw/rtl/prsd_queue.sv =====
module prsd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  prsd_pkg::set_t              wr_data,
  input  logic                        rd_en,
  output prsd_pkg::set_t              rd_data,
  output logic                        not_empty,
  output logic [prsd_pkg::QCNT_BITS-1:0] count
);
  import prsd_pkg::*;

  set_t                 slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;

  assign rd_data   = slots[rd_ptr];
  assign not_empty = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (!wr_en && rd_en) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

endmodule

// ===== hw/rtl/prsd_back.sv =====
module prsd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  prsd_pkg::set_t                  q_data,
  output logic                            q_take,
  input  logic                            pop,
  output logic                            empty,
  output logic [prsd_pkg::SUM_BITS-1:0]   sum_sq_dev,
  output logic [prsd_pkg::RMSD_BITS-1:0]  rmsd_value,
  output logic [prsd_pkg::CNT_BITS-1:0]   pair_count,
  output logic                            overflow_flag
);
  import prsd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int SREM_BITS = ROOT_BITS + 2;

  logic [1:0]           state;
  logic [STEP_BITS-1:0] step;
  logic [SUM_BITS-1:0]  quot;
  logic [CNT_BITS:0]    rem;
  logic [CNT_BITS-1:0]  divisor;
  set_t                 job;
  logic [ROOT_BITS-1:0] root;
  logic [SREM_BITS-1:0] srem;
  logic                 out_valid;

  logic [CNT_BITS:0]    rem_sh;
  logic                 div_ge;
  logic [SREM_BITS+1:0] srem_sh, trial;
  logic                 sqrt_ge;
  logic                 out_free;

  always_comb begin
    rem_sh  = {rem[CNT_BITS-1:0], quot[SUM_BITS-1]};
    div_ge  = rem_sh >= {1'b0, divisor};
    srem_sh = {srem, quot[SUM_BITS-1:SUM_BITS-2]};
    trial   = {2'b00, root, 2'b01};
    sqrt_ge = srem_sh >= trial;
  end

  assign q_take   = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (q_valid) state <= ST_DIV;
        ST_DIV:  if (step == STEP_BITS'(DIV_STEPS - 1)) state <= ST_SQRT;
        ST_SQRT: if (step == STEP_BITS'(SQRT_STEPS - 1)) state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job  <= q_data;
        step <= '0;
        rem  <= '0;
        // A zero count divides as 0 / 1.
        quot    <= (q_data.count == '0) ? '0 : q_data.sum;
        divisor <= (q_data.count == '0) ? CNT_BITS'(1) : q_data.count;
      end
      ST_DIV: begin
        rem  <= div_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
        quot <= {quot[SUM_BITS-2:0], div_ge};
        if (step == STEP_BITS'(DIV_STEPS - 1)) begin
          step <= '0;
          root <= '0;
          srem <= '0;
        end else begin
          step <= step + 1'b1;
        end
      end
      ST_SQRT: begin
        // Restoring square root, two bits of the mean per step.
        srem <= sqrt_ge ? SREM_BITS'(srem_sh - trial) : SREM_BITS'(srem_sh);
        root <= {root[ROOT_BITS-2:0], sqrt_ge};
        quot <= {quot[SUM_BITS-3:0], 2'b00};
        step <= step + 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          sum_sq_dev    <= job.sum;
          pair_count    <= job.count;
          overflow_flag <= job.sat;
          rmsd_value    <= (root > ROOT_BITS'(RMSD_MAX)) ? RMSD_MAX : root[RMSD_BITS-1:0];
        end
      end
      default: step <= '0;
    endcase
  end

endmodule

// ===== hw/rtl/point_set_rmsd.sv =====
// point_set_rmsd: RMS deviation of two streamed 3D point sets.
//
// Input queue: one pair of corresponding points per transfer (push, full),
// signed fixed point. last_pair marks the final pair of a set. A pair is
// taken every cycle while full is low.
// Result queue: one result per set (empty, pop): the saturated sum of squared
// distances, the pair count, the overflow flag and floor(sqrt(sum / count)).
// A result is held on the ports until popped.
// From the transfer of the last pair to empty going low, the set passes the
// difference, square and add stages, is written to and read from the set
// queue, goes through the bit-serial divide and the bit-pair square root,
// and is loaded into the output register.
// Throughput: pairs one per cycle while full is low. The divide and square
// root unit ends one set before it takes the next; up to 4 finished sets
// wait ahead of it, so shorter sets raise full. While the receiver stalls,
// the divider works on and holds its result until the output register frees.
// Reset: empties the queues, clears the running sum, count and overflow flag.
module point_set_rmsd #(
  parameter int COORD_BITS = prsd_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic signed [COORD_BITS-1:0]    ax,
  input  logic signed [COORD_BITS-1:0]    ay,
  input  logic signed [COORD_BITS-1:0]    az,
  input  logic signed [COORD_BITS-1:0]    bx,
  input  logic signed [COORD_BITS-1:0]    by_coord,
  input  logic signed [COORD_BITS-1:0]    bz,
  input  logic                            last_pair,
  output logic                            empty,
  input  logic                            pop,
  output logic [prsd_pkg::SUM_BITS-1:0]   sum_sq_dev,
  output logic [prsd_pkg::RMSD_BITS-1:0]  rmsd_value,
  output logic [prsd_pkg::CNT_BITS-1:0]   pair_count,
  output logic                            overflow_flag
);
  import prsd_pkg::*;

  logic                 accept;
  logic                 set_valid;
  set_t                 set_data;
  logic [1:0]           lasts_in_flight;
  set_t                 q_data;
  logic                 q_valid, q_take;
  logic [QCNT_BITS-1:0] q_count;
  logic [QCNT_BITS:0]   pending;

  // Reserve queue room for every set end still in the front pipeline.
  assign pending = (QCNT_BITS + 1)'(q_count) + (QCNT_BITS + 1)'(lasts_in_flight)
                   + (QCNT_BITS + 1)'(set_valid);
  assign full    = pending >= (QCNT_BITS + 1)'(QDEPTH);
  assign accept  = push && !full;

  prsd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (accept),
    .ax              (ax),
    .ay              (ay),
    .az              (az),
    .bx              (bx),
    .by_coord        (by_coord),
    .bz              (bz),
    .last_pair       (last_pair),
    .set_valid       (set_valid),
    .set_data        (set_data),
    .lasts_in_flight (lasts_in_flight)
  );

  prsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (set_valid),
    .wr_data   (set_data),
    .rd_en     (q_take),
    .rd_data   (q_data),
    .not_empty (q_valid),
    .count     (q_count)
  );

  prsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_take        (q_take),
    .pop           (pop),
    .empty         (empty),
    .sum_sq_dev    (sum_sq_dev),
    .rmsd_value    (rmsd_value),
    .pair_count    (pair_count),
    .overflow_flag (overflow_flag)
  );

endmodule

// ===== hw/rtl/prsd_check.sv =====
module prsd_check #(
  parameter int COORD_BITS = prsd_pkg::COORD_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            push,
  input logic                            full,
  input logic signed [COORD_BITS-1:0]    ax,
  input logic signed [COORD_BITS-1:0]    ay,
  input logic signed [COORD_BITS-1:0]    az,
  input logic signed [COORD_BITS-1:0]    bx,
  input logic signed [COORD_BITS-1:0]    by_coord,
  input logic signed [COORD_BITS-1:0]    bz,
  input logic                            last_pair,
  input logic                            empty,
  input logic                            pop,
  input logic [prsd_pkg::SUM_BITS-1:0]   sum_sq_dev,
  input logic [prsd_pkg::RMSD_BITS-1:0]  rmsd_value,
  input logic [prsd_pkg::CNT_BITS-1:0]   pair_count,
  input logic                            overflow_flag
);
  import prsd_pkg::*;

  localparam int PW = 2 * RMSD_BITS + CNT_BITS + 1;

  logic [PW-1:0] rmsd_sq_cnt;

  assign rmsd_sq_cnt = PW'(rmsd_value) * PW'(rmsd_value) * PW'(pair_count);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sum_sq_dev) && $stable(rmsd_value)
                          && $stable(pair_count) && $stable(overflow_flag)))
    else $error("stalled result changed");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pair_count != '0)
    else $error("result with zero pair count");

  // floor(sqrt(floor(sum / count))) squared, times count, never exceeds the sum.
  a_rmsd_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> rmsd_sq_cnt <= PW'(sum_sq_dev))
    else $error("rmsd too large for sum and count");

endmodule

bind point_set_rmsd prsd_check #(.COORD_BITS(COORD_BITS)) u_prsd_check (.*);
